/* sv/assert_macros.svh */
// Assertion helper macros used by the position unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/tcbp_pkg.sv */
// ----------------------------------------------------------------------------
// tcbp_pkg
// Types and constants for the timed cubic Bezier position unit.
// ----------------------------------------------------------------------------
package tcbp_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CoordWidth = 32;
   localparam logic [31:0] TimeStepReset = 32'd1092;

   typedef struct packed {
      logic        [31:0] elapsed_before;
      logic        [31:0] flight_duration;
      logic signed [31:0] start_coord;
      logic signed [31:0] first_control;
      logic signed [31:0] second_control;
      logic signed [31:0] target_coord;
   } req_type;

   typedef struct packed {
      logic        [31:0] elapsed_after;
      logic signed [31:0] position;
      logic               landed;
   } rsp_type;

endpackage

/* sv/timed_cubic_bezier_position_unit.sv */
// ----------------------------------------------------------------------------
// timed_cubic_bezier_position_unit
// Steps elapsed time, forms t = elapsed/flight by a chain of divider cells
// and evaluates the cubic Bezier point through three lerp cells.
// ----------------------------------------------------------------------------
// channel | direction | handshake    | payload
// req     | in        | valid/stall  | req_type
// rsp     | out       | valid/stall  | rsp_type
// csr     | in        | valid/ready  | time_step
// One item per cycle unless the output stalls; the pipe holds the add stage,
// the overflow stage, FRACTION_BITS_T + 1 divider cells, two stages per lerp
// level and the output register.
// The whole chain advances unless the output register is full and stalled.
// Synchronous reset empties the pipe and loads time_step with 1092.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module timed_cubic_bezier_position_unit #(
   parameter int unsigned FRACTION_BITS_T = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcbp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);
   import tcbp_pkg::*;

   // quotient bits: after < 2*flight leaves FB+1 significant bits; anything
   // larger clamps to one
   localparam int unsigned FB = FRACTION_BITS_T;
   localparam int unsigned QW = FB + 1;
   localparam int unsigned NC = QW + 1;        // cells, one extra for overflow
   localparam logic [FB:0] TOne = (FB+1)'(1) << FB;

   logic [31:0] step_ff;
   logic        advance;
   logic        out_valid_ff;
   rsp_type     out_ff;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= TimeStepReset;
      end else if (csr_valid) begin
         step_ff <= csr_data;
      end
   end

   // stage 0: saturated add
   logic        s0_valid_ff;
   req_type     s0_item_ff;
   logic [31:0] s0_after_ff;
   logic [32:0] sum;
   logic [31:0] after_in;
   assign sum      = {1'b0, req_data.elapsed_before} + {1'b0, step_ff};
   assign after_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
      if (advance) begin
         s0_item_ff  <= req_data;
         s0_after_ff <= after_in;
      end
   end

   // The quotient reaches 2^QW exactly when after >= 2*flight; such items
   // clamp to one and their divider result goes unused. Otherwise only the low QW
   // quotient bits can be set and the divider cells produce them.
   logic        ovf;
   logic [31:0] rem0;
   logic [33:0] dbl;
   assign dbl  = {1'b0, s0_item_ff.flight_duration, 1'b0};
   assign ovf  = {2'b00, s0_after_ff} >= dbl;
   assign rem0 = ovf ? 32'd0 : s0_after_ff;

   // carry overflow/zero-flight alongside the item: t forced later
   logic                   c_valid [NC];
   logic [32:0]            c_rem   [NC];
   logic [QW-1:0]          c_quot  [NC];
   logic [31:0]            c_div   [NC];
   req_type                c_item  [NC];
   logic [31:0]            c_after [NC];
   logic                   force_ff [NC];

   // cell 0 is a pass stage that latches the overflow decision
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid[0] <= 1'b0;
      end else if (advance) begin
         c_valid[0] <= s0_valid_ff;
      end
      if (advance) begin
         c_rem[0]    <= 33'd0;
         c_quot[0]   <= '0;
         c_div[0]    <= rem0;
         c_item[0]   <= s0_item_ff;
         c_after[0]  <= s0_after_ff;
         force_ff[0] <= ovf || (s0_item_ff.flight_duration == 32'd0);
      end
   end

   // The dividend after<<FB is fed MSB first. Preload the remainder with
   // after >> 1 so the first cell shifts in bit 0 and compares after itself;
   // the later cells shift in zeros.
   logic [32:0] r_start;
   logic [31:0] d_start;
   assign r_start = {2'b00, c_div[0][31:1]};
   assign d_start = {c_div[0][0], 31'd0};

   genvar g;
   generate
      for (g = 1; g < NC; g++) begin : g_div
         logic [32:0] rin;
         logic [31:0] din;
         if (g == 1) begin : g_first
            assign rin = r_start;
            assign din = d_start;
         end else begin : g_rest
            assign rin = c_rem[g-1];
            assign din = c_div[g-1];
         end
         tcbp_div_cell #(.QW(QW), .BIT_INDEX(NC - 1 - g)) u_cell (
            .clock        (clock),
            .reset        (reset),
            .advance      (advance),
            .in_valid     (c_valid[g-1]),
            .in_rem       (rin),
            .in_quot      (c_quot[g-1]),
            .in_dividend  (din),
            .in_item      (c_item[g-1]),
            .in_after     (c_after[g-1]),
            .out_valid    (c_valid[g]),
            .out_rem      (c_rem[g]),
            .out_quot     (c_quot[g]),
            .out_dividend (c_div[g]),
            .out_item     (c_item[g]),
            .out_after    (c_after[g])
         );
         always_ff @(posedge clock) begin
            if (advance) begin
               force_ff[g] <= force_ff[g-1];
            end
         end
      end
   endgenerate

   // clamp t and start the Bezier cells
   logic [FB:0]        t_sel;
   logic signed [31:0] p_in [4];
   assign t_sel = (force_ff[NC-1] || c_quot[NC-1] > QW'(TOne)) ? TOne : c_quot[NC-1];
   assign p_in[0] = c_item[NC-1].start_coord;
   assign p_in[1] = c_item[NC-1].first_control;
   assign p_in[2] = c_item[NC-1].second_control;
   assign p_in[3] = c_item[NC-1].target_coord;

   logic               l1_v, l2_v, l3_v;
   logic signed [31:0] l1_p [3];
   logic signed [31:0] l2_p [2];
   logic signed [31:0] l3_p [1];
   logic [FB:0]        l1_t, l2_t, l3_t;
   logic [31:0]        l1_a, l2_a, l3_a;
   logic               l1_l, l2_l, l3_l;
   logic               landed_in;
   assign landed_in = c_after[NC-1] >= c_item[NC-1].flight_duration;

   tcbp_lerp_cell #(.FB(FB), .LANES(3)) u_lerp1 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(c_valid[NC-1]), .in_pts(p_in), .in_t(t_sel),
      .in_after(c_after[NC-1]), .in_landed(landed_in),
      .out_valid(l1_v), .out_pts(l1_p), .out_t(l1_t),
      .out_after(l1_a), .out_landed(l1_l));

   tcbp_lerp_cell #(.FB(FB), .LANES(2)) u_lerp2 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(l1_v), .in_pts(l1_p), .in_t(l1_t),
      .in_after(l1_a), .in_landed(l1_l),
      .out_valid(l2_v), .out_pts(l2_p), .out_t(l2_t),
      .out_after(l2_a), .out_landed(l2_l));

   tcbp_lerp_cell #(.FB(FB), .LANES(1)) u_lerp3 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(l2_v), .in_pts(l2_p), .in_t(l2_t),
      .in_after(l2_a), .in_landed(l2_l),
      .out_valid(l3_v), .out_pts(l3_p), .out_t(l3_t),
      .out_after(l3_a), .out_landed(l3_l));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= l3_v;
      end
      if (advance) begin
         out_ff.elapsed_after <= l3_a;
         out_ff.position      <= l3_p[0];
         out_ff.landed        <= l3_l;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `ASSERT_IMPLIES(a_stall_holds, clock, reset, rsp_valid && rsp_stall, req_stall)
   `ASSERT_NEXT(a_out_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_IMPLIES(a_t_range, clock, reset, c_valid[NC-1], t_sel <= TOne)
   `ASSERT_IMPLIES(a_land_full, clock, reset, l3_v && l3_t == TOne && !l3_l,
                   l3_t == TOne)

endmodule

/* sv/tcbp_div_cell.sv */
// ----------------------------------------------------------------------------
// tcbp_div_cell
// One restoring-division cell: forms one quotient bit per cycle while advance
// is high and passes the partial remainder, the item and its control on to the next cell.
// ----------------------------------------------------------------------------
module tcbp_div_cell #(
   parameter int unsigned QW = 17,
   parameter int unsigned BIT_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [32:0]           in_rem,
   input  logic [QW-1:0]         in_quot,
   input  logic [31:0]           in_dividend,
   input  tcbp_pkg::req_type     in_item,
   input  logic [31:0]           in_after,
   output logic                  out_valid,
   output logic [32:0]           out_rem,
   output logic [QW-1:0]         out_quot,
   output logic [31:0]           out_dividend,
   output tcbp_pkg::req_type     out_item,
   output logic [31:0]           out_after
);
   import tcbp_pkg::*;

   logic              valid_ff;
   logic [32:0]       rem_ff, rem_in;
   logic [QW-1:0]     quot_ff, quot_in;
   logic [31:0]       dividend_ff;
   req_type           item_ff;
   logic [31:0]       after_ff;
   logic [33:0]       trial;
   logic [33:0]       shifted;

   always_comb begin
      shifted = {in_rem, in_dividend[31]};
      trial   = shifted - {2'b00, in_item.flight_duration};
      quot_in = in_quot;
      if (!trial[33]) begin
         rem_in = trial[32:0];
         quot_in[BIT_INDEX] = 1'b1;
      end else begin
         rem_in = shifted[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         rem_ff      <= rem_in;
         quot_ff     <= quot_in;
         dividend_ff <= {in_dividend[30:0], 1'b0};
         item_ff     <= in_item;
         after_ff    <= in_after;
      end
   end

   assign out_valid    = valid_ff;
   assign out_rem      = rem_ff;
   assign out_quot     = quot_ff;
   assign out_dividend = dividend_ff;
   assign out_item     = item_ff;
   assign out_after    = after_ff;

endmodule

/* sv/tcbp_lerp_cell.sv */
// ----------------------------------------------------------------------------
// tcbp_lerp_cell
// One de Casteljau level: multiply stage then round-and-add stage for each
// lane, narrowing the point set by one.
// ----------------------------------------------------------------------------
module tcbp_lerp_cell #(
   parameter int unsigned FB = 16,
   parameter int unsigned LANES = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [31:0]       in_pts [LANES+1],
   input  logic [FB:0]              in_t,
   input  logic [31:0]              in_after,
   input  logic                     in_landed,
   output logic                     out_valid,
   output logic signed [31:0]       out_pts [LANES],
   output logic [FB:0]              out_t,
   output logic [31:0]              out_after,
   output logic                     out_landed
);
   import tcbp_pkg::*;

   localparam int unsigned PW = 33 + FB + 2;

   logic                      v1_ff, v2_ff;
   logic signed [31:0]        a_ff [LANES];
   logic signed [PW-1:0]      prod_ff [LANES];
   logic signed [31:0]        res_ff [LANES];
   logic [FB:0]               t1_ff, t2_ff;
   logic [31:0]               after1_ff, after2_ff;
   logic                      landed1_ff, landed2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         for (int i = 0; i < LANES; i++) begin
            a_ff[i]    <= in_pts[i];
            prod_ff[i] <= PW'(($signed({in_pts[i+1][31], in_pts[i+1]})
                          - $signed({in_pts[i][31], in_pts[i]}))
                          * $signed({1'b0, in_t}));
            res_ff[i]  <= a_ff[i] + 32'((prod_ff[i]
                          + $signed(PW'(1) <<< (FB - 1))) >>> FB);
         end
         t1_ff      <= in_t;
         t2_ff      <= t1_ff;
         after1_ff  <= in_after;
         after2_ff  <= after1_ff;
         landed1_ff <= in_landed;
         landed2_ff <= landed1_ff;
      end
   end

   assign out_valid  = v2_ff;
   assign out_pts    = res_ff;
   assign out_t      = t2_ff;
   assign out_after  = after2_ff;
   assign out_landed = landed2_ff;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timed cubic Bezier position unit. Items are
// driven with random bursts and gaps, the result side stalls at random, and
// every result is compared with a predicted one. The step register is
// rewritten between phases, only while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
   import tcbp_pkg::*;

   localparam int unsigned FracBits = 16;
   localparam longint unsigned TOne = 64'd1 << FracBits;
   localparam int Latency = FracBits + 10;
   localparam int IdleLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   timed_cubic_bezier_position_unit #(.FRACTION_BITS_T(FracBits)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [31:0] step_model;
   rsp_type     expected_positions[$];
   int          error_count = 0;
   int          result_count = 0;
   int          item_count = 0;
   int          idle_cycles = 0;
   bit          hold_off = 1'b0;
   bit          stall_enable = 1'b0;

   function automatic longint lerp_round(longint a, longint b, longint unsigned t);
      longint prod;
      prod = (b - a) * longint'(t);
      return a + ((prod + longint'(TOne / 2)) >>> FracBits);
   endfunction

   function automatic rsp_type predict_position(req_type r);
      longint unsigned after, t;
      longint p0, p1, p2, p3, q0, q1, q2, r0, r1;
      rsp_type o;
      after = longint'(r.elapsed_before) + longint'(step_model);
      if (after > 64'hFFFF_FFFF) after = 64'hFFFF_FFFF;
      if (r.flight_duration == 0) t = TOne;
      else begin
         t = (after << FracBits) / longint'(r.flight_duration);
         if (t > TOne) t = TOne;
      end
      p0 = longint'(r.start_coord);
      p1 = longint'(r.first_control);
      p2 = longint'(r.second_control);
      p3 = longint'(r.target_coord);
      q0 = lerp_round(p0, p1, t);
      q1 = lerp_round(p1, p2, t);
      q2 = lerp_round(p2, p3, t);
      r0 = lerp_round(q0, q1, t);
      r1 = lerp_round(q1, q2, t);
      o.elapsed_after = after[31:0];
      o.position = 32'(lerp_round(r0, r1, t));
      o.landed = (after >= longint'(r.flight_duration));
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
         result_count);
      error_count++;
   endtask

   // check each result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_positions.size() == 0) begin
            $display("unexpected result %0d", result_count);
            error_count++;
         end else begin
            e = expected_positions.pop_front();
            if (rsp_data.elapsed_after !== e.elapsed_after)
               report_mismatch("elapsed_after", rsp_data.elapsed_after, e.elapsed_after);
            if (rsp_data.position !== e.position)
               report_mismatch("position", rsp_data.position, e.position);
            if (rsp_data.landed !== e.landed)
               report_mismatch("landed", 32'(rsp_data.landed), 32'(e.landed));
         end
         result_count++;
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if (stall_enable) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("watchdog expired");
         $display("simulation failed");
         $finish;
      end
   end

   int burst_left = 0;

   // hold valid across a burst; drop it only for a gap
   task automatic send_item(req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = stall_enable ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      expected_positions.push_back(predict_position(r));
      item_count++;
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_time_step(logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      step_model = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_flight();
      req_type r;
      r.flight_duration = $urandom_range(0, 9) == 0 ? random_word()
                          : $urandom_range(1, 32'h0004_0000);
      r.elapsed_before = $urandom_range(0, 9) == 0 ? random_word()
                         : $urandom_range(0, r.flight_duration + 32'h100);
      r.start_coord = random_word();
      r.first_control = random_word();
      r.second_control = random_word();
      r.target_coord = random_word();
      if ($urandom_range(0, 1)) begin
         r.start_coord = $signed(r.start_coord) >>> 12;
         r.first_control = $signed(r.first_control) >>> 12;
         r.second_control = $signed(r.second_control) >>> 12;
         r.target_coord = $signed(r.target_coord) >>> 12;
      end
      return r;
   endfunction

   task automatic test_directed();
      req_type r;
      r = '{32'd0, 32'd0, 32'sd100, 32'sd200, 32'sd300, 32'sd400};
      send_item(r);                                   // zero flight time
      r = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF};
      send_item(r);                                   // elapsed saturates
      r = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000};
      send_item(r);                                   // t near zero
      r = '{32'h0010_0000, 32'h0001_0000, -32'sd5, 32'sd7, -32'sd9, 32'sd11};
      send_item(r);                                   // past flight time
      r = '{32'h0000_8000 - 32'd1092, 32'h0001_0000, 32'sd0, 32'sd1, 32'sd0,
            -32'sd1};
      send_item(r);                                   // t exactly half
      r = '{32'h0001_0000 - 32'd1092, 32'h0001_0000, 32'sd1, 32'sd3, 32'sd5,
            32'sd7};
      send_item(r);                                   // lands exactly
      r = '{32'h0001_0000 - 32'd1093, 32'h0001_0000, 32'sd1, 32'sd3, 32'sd5,
            32'sd7};
      send_item(r);                                   // one tick short
      for (int i = 0; i < 10; i++) send_item(random_flight());
      drain_pipe();
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_item(random_flight());
      drain_pipe();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 80; i++) send_item(random_flight());
      join
      drain_pipe();
   endtask

   initial begin
      step_model = TimeStepReset;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      stall_enable = 1'b1;
      test_random(150);
      write_time_step(32'h0000_0000);
      test_random(60);
      write_time_step(32'hFFFF_FFFF);
      test_random(60);
      write_time_step(32'h0000_4000);
      test_backpressure();
      write_time_step($urandom);
      test_random(120);
      write_time_step(TimeStepReset);
      test_random(40);
      $display("sent %0d items, checked %0d results over six step settings",
         item_count, result_count);
      if (error_count == 0 && expected_positions.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

/* files.f */
+incdir+sv
sv/tcbp_pkg.sv
sv/tcbp_div_cell.sv
sv/tcbp_lerp_cell.sv
sv/timed_cubic_bezier_position_unit.sv
sim/testbench.sv
